>>> rtl/decimal_text_to_fixed_point_macros.svh
// Assertion macros for the decimal text to fixed-point block.
// Included by the top level; no other dependencies.
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_MACROS_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define DTFP_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtfp assertion failed");

// next-cycle implication
`define DTFP_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtfp assertion failed");

`else

`define DTFP_ASSERT_IMP(name, clk, rst, ante, cons)
`define DTFP_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

>>> rtl/dtfp_pkg.sv
// Shared constants, types and the power-of-ten table for the decimal text parser.
// No dependencies.
`timescale 1ns / 1ps

package dtfp_pkg;

   // number format
   localparam int INT_BITS        = 31;
   localparam int FRAC_BITS       = 32;
   localparam int MAX_FRAC_DIGITS = 19;
   localparam int MAG_BITS        = INT_BITS + FRAC_BITS;
   localparam int VALUE_BITS      = 64;
   localparam int CHAR_BITS       = 8;
   localparam int DIGIT_BITS      = 4;
   localparam int FRAC_ACC_BITS   = 64;
   localparam int DIGIT_CNT_BITS  = 5;

   // divider: one quotient bit per step plus one rounding step
   localparam int DIV_STEPS = FRAC_BITS + 1;
   localparam int STEP_BITS = $clog2(DIV_STEPS + 1);

   localparam logic [VALUE_BITS-1:0] MAX_MAG =
      (VALUE_BITS'(1) << MAG_BITS) - VALUE_BITS'(1);
   localparam logic [INT_BITS+DIGIT_BITS-1:0] INT_LIMIT =
      ((INT_BITS+DIGIT_BITS)'(1) << INT_BITS) - (INT_BITS+DIGIT_BITS)'(1);
   localparam logic [DIGIT_CNT_BITS-1:0] FRAC_DIGIT_LIMIT =
      DIGIT_CNT_BITS'(MAX_FRAC_DIGITS);

   // character codes
   localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CH_DOT   = 8'h2E;
   localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;

   // number as parsed so far
   typedef struct packed {
      logic                      negative;
      logic                      saturated;
      logic [INT_BITS-1:0]       int_acc;
      logic [FRAC_ACC_BITS-1:0]  frac_acc;
      logic [DIGIT_CNT_BITS-1:0] frac_cnt;
   } number_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // ten to the n, n up to the fraction digit limit
   function automatic logic [FRAC_ACC_BITS-1:0] pow_ten(input logic [DIGIT_CNT_BITS-1:0] n);
      logic [FRAC_ACC_BITS-1:0] p;
      case (n)
         5'd0:    p = 64'd1;
         5'd1:    p = 64'd10;
         5'd2:    p = 64'd100;
         5'd3:    p = 64'd1000;
         5'd4:    p = 64'd10000;
         5'd5:    p = 64'd100000;
         5'd6:    p = 64'd1000000;
         5'd7:    p = 64'd10000000;
         5'd8:    p = 64'd100000000;
         5'd9:    p = 64'd1000000000;
         5'd10:   p = 64'd10000000000;
         5'd11:   p = 64'd100000000000;
         5'd12:   p = 64'd1000000000000;
         5'd13:   p = 64'd10000000000000;
         5'd14:   p = 64'd100000000000000;
         5'd15:   p = 64'd1000000000000000;
         5'd16:   p = 64'd10000000000000000;
         5'd17:   p = 64'd100000000000000000;
         5'd18:   p = 64'd1000000000000000000;
         5'd19:   p = 64'd10000000000000000000;
         default: p = 64'd1;
      endcase
      return p;
   endfunction

endpackage

>>> rtl/dtfp_parse.sv
// Character parser: sign, integer digits, dot and fraction digits.
// Depends on dtfp_pkg.
`timescale 1ns / 1ps

module dtfp_parse import dtfp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 char_accept,
   input  logic [CHAR_BITS-1:0] char_code,
   input  logic                 char_first,
   output logic                 char_ends,
   output number_type           number
);

   typedef enum logic [1:0] {PH_DONE, PH_START, PH_INT, PH_FRAC} phase_type;

   phase_type  phase_ff, phase_in, phase_cur;
   number_type num_ff, num_in, num_cur;

   logic                              is_digit;
   logic [DIGIT_BITS-1:0]             digit;
   logic [CHAR_BITS-1:0]              digit_wide;
   logic [INT_BITS+DIGIT_BITS-1:0]    int_ext, int_next;
   logic [FRAC_ACC_BITS-1:0]          frac_next;

   // a first flag restarts the string before this character is looked at
   assign phase_cur = char_first ? PH_START : phase_ff;
   assign num_cur   = char_first ? '0 : num_ff;
   assign number    = num_cur;

   assign is_digit   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
   assign digit_wide = char_code - CH_ZERO;
   assign digit      = digit_wide[DIGIT_BITS-1:0];

   // times ten plus digit, as shift and add
   assign int_ext  = {{DIGIT_BITS{1'b0}}, num_cur.int_acc};
   assign int_next = (int_ext << 3) + (int_ext << 1)
                   + {{INT_BITS{1'b0}}, digit};
   assign frac_next = (num_cur.frac_acc << 3) + (num_cur.frac_acc << 1)
                    + {{(FRAC_ACC_BITS-DIGIT_BITS){1'b0}}, digit};

   // per-character decision
   always_comb begin
      phase_in  = phase_cur;
      num_in    = num_cur;
      char_ends = 1'b0;
      case (phase_cur)
         PH_START, PH_INT: begin
            if ((phase_cur == PH_START) &&
                ((char_code == CH_MINUS) || (char_code == CH_PLUS))) begin
               num_in.negative = (char_code == CH_MINUS);
               phase_in        = PH_INT;
            end else if (is_digit) begin
               phase_in = PH_INT;
               if (!num_cur.saturated) begin
                  if (int_next > INT_LIMIT) begin
                     num_in.saturated = 1'b1;
                     num_in.int_acc   = INT_LIMIT[INT_BITS-1:0];
                  end else begin
                     num_in.int_acc = int_next[INT_BITS-1:0];
                  end
               end
            end else if (char_code == CH_DOT) begin
               phase_in = PH_FRAC;
            end else begin
               char_ends = 1'b1;
               phase_in  = PH_DONE;
            end
         end
         PH_FRAC: begin
            if (is_digit) begin
               if (num_cur.frac_cnt < FRAC_DIGIT_LIMIT) begin
                  num_in.frac_acc = frac_next;
                  num_in.frac_cnt = num_cur.frac_cnt + DIGIT_CNT_BITS'(1);
               end
            end else begin
               char_ends = 1'b1;
               phase_in  = PH_DONE;
            end
         end
         default: begin
            // done: characters are ignored
            phase_in = phase_cur;
         end
      endcase
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DONE;
         num_ff   <= '0;
      end else if (char_accept) begin
         phase_ff <= phase_in;
         num_ff   <= num_in;
      end
   end

endmodule

>>> rtl/dtfp_div.sv
// Shared restoring divider: fraction digits times 2^FRAC_BITS over ten to the count.
// One quotient bit per cycle, last bit is the rounding bit. Depends on dtfp_pkg.
`timescale 1ns / 1ps

module dtfp_div import dtfp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [FRAC_ACC_BITS-1:0] dividend,
   input  logic [FRAC_ACC_BITS-1:0] divisor,
   output div_status_type           status,
   output logic [DIV_STEPS-1:0]     quot_bits
);

   typedef enum logic [1:0] {DV_IDLE, DV_CLAMP, DV_RUN} div_state_type;

   div_state_type            state_ff, state_in;
   logic [FRAC_ACC_BITS-1:0] rem_ff, rem_in;
   logic [FRAC_ACC_BITS-1:0] dsr_ff, dsr_in;
   logic [DIV_STEPS-1:0]     quot_ff, quot_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;
   logic                     done_ff, done_in;

   logic [FRAC_ACC_BITS:0]   rem_shift;
   logic                     take;

   // one trial subtract per cycle, the bit shifted out of the top counts
   assign rem_shift = {rem_ff, 1'b0};
   assign take      = rem_shift >= {1'b0, dsr_ff};

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      quot_in  = quot_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      case (state_ff)
         DV_IDLE: begin
            if (start) begin
               rem_in   = dividend;
               dsr_in   = divisor;
               quot_in  = '0;
               step_in  = STEP_BITS'(DIV_STEPS);
               state_in = DV_CLAMP;
            end
         end
         DV_CLAMP: begin
            // remainder must start below the divisor
            if (rem_ff >= dsr_ff) begin
               rem_in = dsr_ff - FRAC_ACC_BITS'(1);
            end
            state_in = DV_RUN;
         end
         DV_RUN: begin
            rem_in  = take ? FRAC_ACC_BITS'(rem_shift - {1'b0, dsr_ff})
                           : rem_shift[FRAC_ACC_BITS-1:0];
            quot_in = {quot_ff[DIV_STEPS-2:0], take};
            step_in = step_ff - STEP_BITS'(1);
            if (step_ff == STEP_BITS'(1)) begin
               done_in  = 1'b1;
               state_in = DV_IDLE;
            end
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

   // sequencer state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         step_ff  <= step_in;
      end
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quot_ff <= quot_in;
   end

   assign status.busy = (state_ff != DV_IDLE);
   assign status.done = done_ff;
   assign quot_bits   = quot_ff;

endmodule

>>> rtl/decimal_text_to_fixed_point.sv
// Top level: decimal text stream in, signed Q31.32 value out.
// Depends on dtfp_pkg, dtfp_parse, dtfp_div and the assertion macro header.
//
//   channel   direction  tdata                 tuser
//   req_      in         char_code[7:0]        first
//   rsp_      out        value[63:0] signed    overflow
//
// A sign, digit, dot or ignored beat leaves the state idle; req_tready stays high for the next.
// A beat that ends a number passes through accept, the divider clamp step, one divider
// step per fraction bit plus a rounding step, done handoff, combine and output load.
// req_tready is low meanwhile, as the single divider serves one number at a time.
// The load waits while the output register still holds a result not yet taken.
// reset is synchronous and clears all control state; parser starts ignoring input.
`timescale 1ns / 1ps
`include "decimal_text_to_fixed_point_macros.svh"

module decimal_text_to_fixed_point import dtfp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CHAR_BITS-1:0]  req_tdata,   // [7:0] char_code
   input  logic                  req_tuser,   // [0] first
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [VALUE_BITS-1:0] rsp_tdata,   // [63:0] value
   output logic                  rsp_tuser    // [0] overflow
);

   typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_COMBINE, ST_EMIT} state_type;

   state_type                state_ff, state_in;
   logic                     neg_ff, neg_in;
   logic                     sat_ff, sat_in;
   logic [INT_BITS-1:0]      int_ff, int_in;
   logic [VALUE_BITS-1:0]    mag_ff, mag_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]    rsp_value_ff, rsp_value_in;
   logic                     rsp_ovf_ff, rsp_ovf_in;

   logic                     req_beat;
   logic                     char_ends;
   number_type               number;
   logic                     div_start;
   div_status_type           div_status;
   logic [DIV_STEPS-1:0]     quot_bits;
   logic [VALUE_BITS-1:0]    mag_sum;
   logic                     rsp_at_limit;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign div_start  = req_beat && char_ends;

   // character parser
   dtfp_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .char_accept (req_beat),
      .char_code   (req_tdata),
      .char_first  (req_tuser),
      .char_ends   (char_ends),
      .number      (number)
   );

   // fraction divider
   dtfp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (number.frac_acc),
      .divisor   (pow_ten(number.frac_cnt)),
      .status    (div_status),
      .quot_bits (quot_bits)
   );

   // integer part, fraction bits and rounding bit in one add
   assign mag_sum = {{(VALUE_BITS-MAG_BITS){1'b0}}, int_ff, {FRAC_BITS{1'b0}}}
                  + {{(VALUE_BITS-FRAC_BITS){1'b0}}, quot_bits[DIV_STEPS-1:1]}
                  + {{(VALUE_BITS-1){1'b0}}, quot_bits[0]};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      sat_in       = sat_ff;
      int_in       = int_ff;
      mag_in       = mag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      case (state_ff)
         ST_IDLE: begin
            if (div_start) begin
               neg_in   = number.negative;
               sat_in   = number.saturated;
               int_in   = number.int_acc;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = ST_COMBINE;
            end
         end
         ST_COMBINE: begin
            // saturation overrides, rounding carry clamps at the top
            if (sat_ff || (mag_sum > MAX_MAG)) begin
               mag_in = MAX_MAG;
            end else begin
               mag_in = mag_sum;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = neg_ff ? (~mag_ff + VALUE_BITS'(1)) : mag_ff;
               rsp_ovf_in   = sat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff       <= neg_in;
      sat_ff       <= sat_in;
      int_ff       <= int_in;
      mag_ff       <= mag_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   // result sits at the largest magnitude, either sign
   assign rsp_at_limit = (rsp_tdata == MAX_MAG) || (rsp_tdata == (~MAX_MAG + VALUE_BITS'(1)));

   // checks
   `DTFP_ASSERT_IMP(a_no_beat_while_dividing, clock, reset, req_beat, !div_status.busy)
   `DTFP_ASSERT_IMP(a_div_done_in_divide, clock, reset, div_status.done, state_ff == ST_DIVIDE)
   `DTFP_ASSERT_IMP(a_overflow_saturates, clock, reset, rsp_tvalid && rsp_tuser, rsp_at_limit)

endmodule
